// ----- sv/supq_pkg.sv -----
package supq_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    typedef logic [1:0]        t_op;
    typedef logic [2:0]        t_status;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [OCC_W-1:0]  t_occ;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the incoming word
        logic cmp;     // broadcast compare against all slots
        logic upd;     // shift slots, update count, form result
    } t_cmd;

endpackage

// ----- sv/supq_ctrl.sv -----
module supq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output supq_pkg::t_cmd o_cmd,
    output logic          o_valid
);
    import supq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_strobe;

    // advance through compare and update for each accepted word
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_CMP;
            end
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_UPD);
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.cmp  = (r_state == S_CMP);
    assign o_cmd.upd  = (r_state == S_UPD);
    assign o_valid   = r_strobe;

endmodule

// ----- sv/supq_dp.sv -----
module supq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  supq_pkg::t_cmd    i_cmd,
    input  supq_pkg::t_op     i_op,
    input  supq_pkg::t_data   i_value,
    output supq_pkg::t_status o_status,
    output supq_pkg::t_data   o_data_out,
    output supq_pkg::t_occ    o_occupancy
);
    import supq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_data             r_slot [CAPACITY];
    logic [CNT_W-1:0]  r_count, n_count;
    t_op               r_op;
    logic signed [DATA_W-1:0] r_value;
    logic [CAPACITY-1:0] r_lt, r_eq;
    t_status           r_status, n_status;
    t_data             r_data, n_data;
    logic              ins_ok, rem_ok, dup, full, empty;
    logic [CNT_W+OCC_W-1:0] count_ext;

    // hold the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
        end
    end

    // per-slot compare and shift cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic live;
        assign live = (CNT_W'(i) < r_count);

        always_ff @(posedge i_clk) begin
            if (i_cmd.cmp) begin
                r_lt[i] <= live && ($signed(r_slot[i]) < r_value);
                r_eq[i] <= live && (r_slot[i] == t_data'(r_value));
            end
        end

        always_ff @(posedge i_clk) begin
            if (ins_ok && !r_lt[i]) begin
                if (i == 0) begin
                    r_slot[i] <= t_data'(r_value);
                end else if (r_lt[(i == 0) ? 0 : i-1]) begin
                    r_slot[i] <= t_data'(r_value);
                end else begin
                    r_slot[i] <= r_slot[(i == 0) ? 0 : i-1];
                end
            end else if (rem_ok && (i < CAPACITY - 1)) begin
                r_slot[i] <= r_slot[(i < CAPACITY - 1) ? i+1 : i];
            end
        end
    end

    assign dup    = |r_eq;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign empty  = (r_count == '0);
    assign ins_ok = i_cmd.upd && (r_op == OP_INSERT) && !dup && !full;
    assign rem_ok = i_cmd.upd && (r_op == OP_REMOVE) && !empty;

    // form the result and next count
    always_comb begin
        n_status = ST_OK;
        n_data   = '0;
        n_count  = r_count;
        case (r_op)
            OP_INSERT: begin
                if (dup)       n_status = ST_DUP;
                else if (full) n_status = ST_FULL;
                else           n_count  = r_count + CNT_W'(1);
            end
            OP_REMOVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data  = r_slot[0];
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_SEARCH: begin
                n_status = dup ? ST_OK : ST_MISS;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    assign count_ext   = {{OCC_W{1'b0}}, r_count};
    assign o_status    = r_status;
    assign o_data_out  = r_data;
    assign o_occupancy = count_ext[OCC_W-1:0];

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("slot count above capacity");

    // compare flags form a prefix: a slot below v implies all lower slots are too
    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.cmp) |-> ((r_lt & (r_lt + CAPACITY'(1))) == '0) && $onehot0(r_eq))
        else $error("compare flags not sorted");

    // a successful insert bumps the count by one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_ok |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow count");

endmodule

// ----- sv/sorted_unique_priority_queue_top.sv -----
// A word taken on start appears on the result ports after the compare and update
// states, as a one-cycle o_valid strobe; the receiver cannot stall it.
// A word is taken only while idle: capture, compare in all slot cells,
// shift and update run in turn; busy is high through compare and update.
// Reset (synchronous, active low) empties the queue; slot contents are not cleared.
module sorted_unique_priority_queue_top #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  supq_pkg::t_op     i_op,
    input  supq_pkg::t_data   i_value,
    output logic              o_valid,
    output supq_pkg::t_status o_status,
    output supq_pkg::t_data   o_data_out,
    output supq_pkg::t_occ    o_occupancy
);
    import supq_pkg::*;

    t_cmd cmd;

    supq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    supq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_occupancy (o_occupancy)
    );

    // an accepted word keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // result strobe follows acceptance once compare and update are done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_valid)
        else $error("result strobe missing");

    // only a successful remove returns data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_data_out == '0)
        else $error("data on failed operation");

endmodule
